// ----- design/sm4bcm_pkg.sv -----
// Shared types, constants and round functions of the SM4 chaining-mode block.
`timescale 1ns / 1ps

package sm4bcm_pkg;

	localparam int SM4_ROUND_COUNT = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IV_HIGH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IV_LOW = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAIN_MODE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 3'd5;

	localparam logic DIR_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CFB = 2'd2,
		MODE_OFB = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUNDS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_key;
		logic load_data;
		logic round_en;
		logic key_sched;
		logic finish;
	} ctrl_t;

	localparam logic [31:0] FK [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Byte-wise S-box substitution of a word.
	function automatic logic [31:0] sbox_word(input logic [31:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [31:0] lin_data(input logic [31:0] t);
		return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] t);
		return t ^ rotl(t, 13) ^ rotl(t, 23);
	endfunction

	// Key schedule constant: byte j of word i is (4*i + j) * 7 modulo 256.
	function automatic logic [31:0] ck_word(input logic [7:0] i);
		logic [31:0] v;
		logic [7:0] b;
		v = '0;
		for (int j = 0; j < 4; j++) begin
			b = 8'((10'(i) * 10'd4 + 10'(j)) * 10'd7);
			v = {v[23:0], b};
		end
		return v;
	endfunction

endpackage

// ----- design/sm4bcm_round.sv -----
// Shared SM4 round unit, used for both key expansion and the cipher rounds.
`timescale 1ns / 1ps

module sm4bcm_round import sm4bcm_pkg::*; (
	input  logic [31:0] w0,
	input  logic [31:0] w1,
	input  logic [31:0] w2,
	input  logic [31:0] w3,
	input  logic [31:0] rk,
	input  logic        key_sched,
	output logic [31:0] next_word
);

	logic [31:0] t;

	always_comb begin
		t = sbox_word(w1 ^ w2 ^ w3 ^ rk);
		next_word = w0 ^ (key_sched ? lin_key(t) : lin_data(t));
	end

endmodule

// ----- design/sm4bcm_ctrl.sv -----
// Sequencer that steps the shared round unit through key expansion and cipher rounds.
`timescale 1ns / 1ps

module sm4bcm_ctrl import sm4bcm_pkg::*; #(
	parameter int ROUND_COUNT = SM4_ROUND_COUNT,
	localparam int RW = $clog2(ROUND_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          block_valid,
	input  logic          keys_current,
	input  logic          out_free,
	output logic          block_stall,
	output ctrl_t         ctrl,
	output logic [RW-1:0] round_idx
);

	localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

	state_t state_q, state_d;
	logic [RW-1:0] cnt_q;
	logic last;

	assign round_idx = cnt_q;
	assign last = (cnt_q == LAST_ROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.round_en && !last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		block_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				block_stall = 1'b0;
				if (block_valid) begin
					ctrl.accept = 1'b1;
					if (keys_current) begin
						state_d = ST_LOAD;
					end else begin
						ctrl.load_key = 1'b1;
						state_d = ST_EXPAND;
					end
				end
			end
			ST_EXPAND: begin
				ctrl.round_en = 1'b1;
				ctrl.key_sched = 1'b1;
				if (last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctrl.load_data = 1'b1;
				state_d = ST_ROUNDS;
			end
			ST_ROUNDS: begin
				ctrl.round_en = 1'b1;
				if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ctrl.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/sm4_block_cipher_modes.sv -----
// Top level of the SM4 block cipher with ECB, CBC, CFB and OFB chaining.
`timescale 1ns / 1ps

// Usage:
// Configuration is written through cfg_valid/cfg_ready with a register index and
// 64-bit data; cfg_ready is always high. The user must write configuration only
// while the block is idle; the block itself does not enforce this. Any write to
// a defined register marks the round keys stale, so the next item first expands
// the key and reloads the chaining value from the IV. Input items arrive on
// block_valid/block_stall, results leave on result_valid/result_stall; an item
// moves when valid is high and stall low. One shared round unit does one round
// per cycle. With current keys an item goes through a load step, the cipher
// rounds and a write to the output register; a stale key adds a key expansion
// pass for that item. The block takes one item at a time and stalls its input
// until the result is written. When the receiver stalls, the result stays in
// the output register and a finished item waits in the sequencer until that
// register is free. Reset clears the configuration registers to zero, marks the
// keys stale and empties the output register.
module sm4_block_cipher_modes import sm4bcm_pkg::*; #(
	parameter int ROUND_COUNT = SM4_ROUND_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   block_valid,
	output logic                   block_stall,
	input  logic [63:0]            block_high,
	input  logic [63:0]            block_low,
	input  logic                   end_of_message,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [63:0]            result_high,
	output logic [63:0]            result_low,
	output logic                   result_last
);

	localparam int RW = $clog2(ROUND_COUNT);
	localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	mode_t mode_q;
	logic dir_q;
	logic keys_current_q;
	logic [127:0] chain_q, in_blk_q;
	logic eom_q;
	logic [31:0] word_q [4];
	logic [31:0] rk_q [ROUND_COUNT];
	logic [63:0] result_high_q, result_low_q;
	logic result_last_q, result_valid_q;

	ctrl_t ctrl;
	logic [RW-1:0] round_idx, rk_sel;
	logic out_free, dec, reverse, cfg_hit;
	logic [31:0] rk, next_word;
	logic [127:0] e_blk, src_blk, res_blk, chain_nxt, key_blk;

	assign cfg_ready = 1'b1;
	assign out_free = !result_valid_q || !result_stall;
	assign dec = (dir_q == DIR_DECRYPT);
	assign reverse = dec && (mode_q == MODE_ECB || mode_q == MODE_CBC);
	assign rk_sel = reverse ? (LAST_ROUND - round_idx) : round_idx;
	assign rk = ctrl.key_sched ? ck_word(8'(round_idx)) : rk_q[rk_sel];
	assign e_blk = {word_q[3], word_q[2], word_q[1], word_q[0]};
	assign key_blk = {key_high_q, key_low_q} ^ {FK[0], FK[1], FK[2], FK[3]};
	assign cfg_hit = cfg_valid && cfg_ready && (cfg_index <= REG_DIRECTION);

	assign result_valid = result_valid_q;
	assign result_high = result_high_q;
	assign result_low = result_low_q;
	assign result_last = result_last_q;

	sm4bcm_ctrl #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.block_valid(block_valid),
		.keys_current(keys_current_q),
		.out_free(out_free),
		.block_stall(block_stall),
		.ctrl(ctrl),
		.round_idx(round_idx)
	);

	sm4bcm_round u_round (
		.w0(word_q[0]),
		.w1(word_q[1]),
		.w2(word_q[2]),
		.w3(word_q[3]),
		.rk(rk),
		.key_sched(ctrl.key_sched),
		.next_word(next_word)
	);

	// Block entering the rounds, chosen by the chaining mode.
	always_comb begin
		unique case (mode_q)
			MODE_ECB: src_blk = in_blk_q;
			MODE_CBC: src_blk = dec ? in_blk_q : (in_blk_q ^ chain_q);
			MODE_CFB: src_blk = chain_q;
			MODE_OFB: src_blk = chain_q;
			default: src_blk = in_blk_q;
		endcase
	end

	// Result and next chaining value once the rounds are done.
	always_comb begin
		unique case (mode_q)
			MODE_ECB: begin
				res_blk = e_blk;
				chain_nxt = chain_q;
			end
			MODE_CBC: begin
				res_blk = dec ? (e_blk ^ chain_q) : e_blk;
				chain_nxt = dec ? in_blk_q : e_blk;
			end
			MODE_CFB: begin
				res_blk = e_blk ^ in_blk_q;
				chain_nxt = dec ? in_blk_q : (e_blk ^ in_blk_q);
			end
			MODE_OFB: begin
				res_blk = e_blk ^ in_blk_q;
				chain_nxt = e_blk;
			end
			default: begin
				res_blk = e_blk;
				chain_nxt = chain_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
			mode_q <= MODE_ECB;
			dir_q <= 1'b0;
			keys_current_q <= 1'b0;
			chain_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW: key_low_q <= cfg_data;
					REG_IV_HIGH: iv_high_q <= cfg_data;
					REG_IV_LOW: iv_low_q <= cfg_data;
					REG_CHAIN_MODE: mode_q <= mode_t'(cfg_data[1:0]);
					REG_DIRECTION: dir_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cfg_hit) begin
				keys_current_q <= 1'b0;
			end else if (ctrl.load_key) begin
				keys_current_q <= 1'b1;
			end
			if (ctrl.load_key) begin
				chain_q <= {iv_high_q, iv_low_q};
			end else if (ctrl.finish) begin
				chain_q <= chain_nxt;
			end
			if (ctrl.finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			in_blk_q <= {block_high, block_low};
			eom_q <= end_of_message;
		end
		if (ctrl.load_key) begin
			word_q[0] <= key_blk[127:96];
			word_q[1] <= key_blk[95:64];
			word_q[2] <= key_blk[63:32];
			word_q[3] <= key_blk[31:0];
		end else if (ctrl.load_data) begin
			word_q[0] <= src_blk[127:96];
			word_q[1] <= src_blk[95:64];
			word_q[2] <= src_blk[63:32];
			word_q[3] <= src_blk[31:0];
		end else if (ctrl.round_en) begin
			word_q[0] <= word_q[1];
			word_q[1] <= word_q[2];
			word_q[2] <= word_q[3];
			word_q[3] <= next_word;
		end
		if (ctrl.round_en && ctrl.key_sched) begin
			rk_q[round_idx] <= next_word;
		end
		if (ctrl.finish) begin
			result_high_q <= res_blk[127:64];
			result_low_q <= res_blk[63:0];
			result_last_q <= eom_q;
		end
	end

endmodule

// ----- design/sm4bcm_checker.sv -----
// Port-level checks of the SM4 chaining-mode block and their binding.
`timescale 1ns / 1ps

module sm4bcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        block_valid,
	input logic        block_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [63:0] result_high,
	input logic [63:0] result_low,
	input logic        result_last
);

	// A stalled result item holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_high)
			&& $stable(result_low) && $stable(result_last))
		else $error("stalled result item changed");

	// Once an item is taken, the block is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && !block_stall |=> block_stall)
		else $error("input not stalled after accepting an item");

	// No result can appear in the cycle right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && !block_stall |=> !$rose(result_valid))
		else $error("result appeared one cycle after acceptance");

	// The sequencer goes idle in the same cycle the result is posted.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !block_stall)
		else $error("input still stalled when a new result was posted");

endmodule

bind sm4_block_cipher_modes sm4bcm_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.block_valid(block_valid),
	.block_stall(block_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_high(result_high),
	.result_low(result_low),
	.result_last(result_last)
);

// ----- tb/sm4_block_cipher_modes_tb.sv -----
// Self-checking testbench for the SM4 cipher block with ECB, CBC, CFB and OFB chaining.
`timescale 1ns / 1ps

module sm4_block_cipher_modes_tb;
	import sm4bcm_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic DIR_ENCRYPT = 1'b0;
	localparam int RANDOM_ITEMS = 1500;

	localparam logic [31:0] SYS_PARAM [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] S_TABLE [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] low;
		logic        last;
	} cipher_block_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   block_valid;
	logic                   block_stall;
	logic [63:0]            block_high;
	logic [63:0]            block_low;
	logic                   end_of_message;
	logic                   result_valid;
	logic                   result_stall;
	logic [63:0]            result_high;
	logic [63:0]            result_low;
	logic                   result_last;

	// Shadow copy of the block's registers and chaining state.
	logic [63:0]  cfg_key_high = '0;
	logic [63:0]  cfg_key_low = '0;
	logic [63:0]  cfg_iv_high = '0;
	logic [63:0]  cfg_iv_low = '0;
	mode_t        cfg_mode = MODE_ECB;
	logic         cfg_dir = DIR_ENCRYPT;
	logic [31:0]  round_keys [32];
	logic [127:0] chain_word = '0;
	logic         keys_ready = 1'b0;

	cipher_block_t awaited_blocks [$];
	int unsigned   mismatch_count = 0;
	int unsigned   burst_left = 0;
	logic          valid_up = 1'b0;
	int unsigned   stall_run = 0;
	logic          stall_hold = 1'b0;

	sm4_block_cipher_modes dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.block_valid    (block_valid),
		.block_stall    (block_stall),
		.block_high     (block_high),
		.block_low      (block_low),
		.end_of_message (end_of_message),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_high    (result_high),
		.result_low     (result_low),
		.result_last    (result_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] rol32(input logic [31:0] w, input int unsigned s);
		return (w << s) | (w >> (32 - s));
	endfunction

	function automatic logic [31:0] tau_word(input logic [31:0] w);
		logic [31:0] r;
		for (int b = 0; b < 4; b++)
			r[8*b +: 8] = S_TABLE[w[8*b +: 8]];
		return r;
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] ck, t, n;
		logic [127:0] key;
		key = {cfg_key_high, cfg_key_low};
		for (int w = 0; w < 4; w++)
			k[w] = key[127 - 32*w -: 32] ^ SYS_PARAM[w];
		for (int i = 0; i < 32; i++) begin
			for (int j = 0; j < 4; j++)
				ck[31 - 8*j -: 8] = 8'((4*i + j) * 7);
			t = tau_word(k[1] ^ k[2] ^ k[3] ^ ck);
			n = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = n;
			round_keys[i] = n;
		end
	endfunction

	function automatic logic [127:0] sm4_crypt(input logic [127:0] blk, input logic inverse);
		logic [31:0] x [4];
		logic [31:0] rk, t, n;
		for (int w = 0; w < 4; w++)
			x[w] = blk[127 - 32*w -: 32];
		for (int i = 0; i < 32; i++) begin
			rk = round_keys[inverse ? 31 - i : i];
			t = tau_word(x[1] ^ x[2] ^ x[3] ^ rk);
			n = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = n;
		end
		return {x[3], x[2], x[1], x[0]};
	endfunction

	// Advances the shadow chaining state by one item and returns its output block.
	function automatic logic [127:0] sm4_chain_step(input logic [127:0] din);
		logic [127:0] ks, dout;
		if (!keys_ready) begin
			expand_round_keys();
			chain_word = {cfg_iv_high, cfg_iv_low};
			keys_ready = 1'b1;
		end
		case (cfg_mode)
		MODE_ECB: dout = sm4_crypt(din, cfg_dir == DIR_DECRYPT);
		MODE_CBC: begin
			if (cfg_dir == DIR_DECRYPT) begin
				dout = sm4_crypt(din, 1'b1) ^ chain_word;
				chain_word = din;
			end else begin
				dout = sm4_crypt(din ^ chain_word, 1'b0);
				chain_word = dout;
			end
		end
		MODE_CFB: begin
			ks = sm4_crypt(chain_word, 1'b0);
			dout = ks ^ din;
			chain_word = (cfg_dir == DIR_DECRYPT) ? din : dout;
		end
		default: begin
			ks = sm4_crypt(chain_word, 1'b0);
			chain_word = ks;
			dout = ks ^ din;
		end
		endcase
		return dout;
	endfunction

	function automatic logic [63:0] wide_value();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: MISMATCH %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		cipher_block_t oldest;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_blocks.size() == 0) begin
				report_mismatch("result with no item pending, high", result_high, '0);
			end else begin
				oldest = awaited_blocks.pop_front();
				if (result_high !== oldest.high)
					report_mismatch("result_high", result_high, oldest.high);
				if (result_low !== oldest.low)
					report_mismatch("result_low", result_low, oldest.low);
				if (result_last !== oldest.last)
					report_mismatch("result_last", 64'(result_last), 64'(oldest.last));
			end
		end
	end

	// Receiver stalls in runs of random length; long clear runs leave stretches unstalled.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_hold = ($urandom_range(0, 2) == 0);
			stall_run = stall_hold ? $urandom_range(1, 12) : $urandom_range(1, 50);
		end
		stall_run--;
		result_stall <= stall_hold;
	end

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic last);
		cipher_block_t predicted;
		block_valid <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		end_of_message <= last;
		valid_up = 1'b1;
		@(posedge clk);
		while (block_stall)
			@(posedge clk);
		predicted.last = last;
		{predicted.high, predicted.low} = sm4_chain_step({hi, lo});
		awaited_blocks.push_back(predicted);
		if (burst_left == 0) begin
			block_valid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	// The sender holds off until every pending result has been taken.
	task automatic wait_results_drained();
		if (valid_up) begin
			block_valid <= 1'b0;
			valid_up = 1'b0;
		end
		while (awaited_blocks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		REG_KEY_HIGH: cfg_key_high = data;
		REG_KEY_LOW: cfg_key_low = data;
		REG_IV_HIGH: cfg_iv_high = data;
		REG_IV_LOW: cfg_iv_low = data;
		REG_CHAIN_MODE: cfg_mode = mode_t'(data[1:0]);
		REG_DIRECTION: cfg_dir = data[0];
		default: ;
		endcase
		if (idx <= REG_DIRECTION)
			keys_ready = 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Power-up settings: all-zero key and IV, ECB encryption.
	task automatic test_reset_config();
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b1);
		send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
	endtask

	task automatic test_known_answer();
		write_reg(REG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
		write_reg(REG_KEY_LOW, 64'hfedc_ba98_7654_3210);
		write_reg(REG_CHAIN_MODE, 64'(MODE_ECB));
		write_reg(REG_DIRECTION, 64'(DIR_ENCRYPT));
		send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
		write_reg(REG_DIRECTION, 64'(DIR_DECRYPT));
		send_block(64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246, 1'b1);
	endtask

	// Two chained items per mode and direction; register writes carry set upper bits.
	task automatic test_chain_modes();
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_IV_HIGH, '1);
		write_reg(REG_IV_LOW, '1);
		for (int m = MODE_ECB; m <= MODE_OFB; m++) begin
			for (int d = 0; d < 2; d++) begin
				write_reg(REG_CHAIN_MODE, {{62{1'b1}}, 2'(m)});
				write_reg(REG_DIRECTION, {{63{1'b1}}, 1'(d)});
				send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
				send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
			end
			write_reg(REG_IV_HIGH, {$urandom, $urandom});
			write_reg(REG_IV_LOW, {$urandom, $urandom});
		end
	endtask

	// Writes to undefined indexes must leave the chaining value untouched.
	task automatic test_spare_index();
		write_reg(REG_CHAIN_MODE, 64'(MODE_CBC));
		write_reg(REG_DIRECTION, 64'(DIR_ENCRYPT));
		send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		write_reg(REG_SPARE_A, {$urandom, $urandom});
		write_reg(REG_SPARE_B, '1);
		send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
	endtask

	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned len;
		logic wrote;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// Most messages start from fresh settings; the rest continue the chain.
			if ($urandom_range(0, 4) != 0) begin
				wrote = 1'b0;
				for (int r = REG_KEY_HIGH; r <= REG_DIRECTION; r++) begin
					if ($urandom_range(0, 1) == 1) begin
						write_reg(CFG_INDEX_W'(r), wide_value());
						wrote = 1'b1;
					end
				end
				if (!wrote)
					write_reg(REG_CHAIN_MODE, wide_value());
				if ($urandom_range(0, 7) == 0)
					write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, wide_value());
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				send_block(wide_value(), wide_value(),
						(i == len - 1) ^ ($urandom_range(0, 15) == 0));
			sent += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		block_valid <= 1'b0;
		block_high <= '0;
		block_low <= '0;
		end_of_message <= 1'b0;
		result_stall <= 1'b0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_known_answer();
		test_chain_modes();
		test_spare_index();
		test_random_traffic();

		wait_results_drained();
		// Any stray result would show up within one expansion plus one item.
		repeat (100)
			@(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
